// ----- hw/rtl/dvrt_pkg.sv -----
package dvrt_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int PCNT_W = 3;

    localparam logic [1:0] OP_UPDATE   = 2'd0;
    localparam logic [1:0] OP_PERIODIC = 2'd1;
    localparam logic [1:0] OP_CHECK    = 2'd2;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    localparam logic [2:0] REG_INFINITY_COST = 3'd0;
    localparam logic [2:0] REG_SPLIT_HORIZON = 3'd1;
    localparam logic [2:0] REG_POISON_REV    = 3'd2;
    localparam logic [2:0] REG_SELF_NODE     = 3'd3;
    localparam logic [2:0] REG_PORTS_IN_USE  = 3'd4;
    localparam logic [2:0] REG_PEER_TIMEOUT  = 3'd5;

    localparam logic [7:0]  RST_INFINITY_COST = 8'd16;
    localparam logic [2:0]  RST_PORTS_IN_USE  = 3'd4;
    localparam logic [31:0] RST_PEER_TIMEOUT  = 32'd1000;

    typedef struct packed {
        logic [7:0]  infinity_cost;
        logic        split_horizon_on;
        logic        poison_reverse_on;
        logic [3:0]  self_node_id;
        logic [2:0]  ports_in_use;
        logic [31:0] peer_timeout;
    } cfg_t;

    typedef struct packed {
        logic route_set;
        logic route_drop;
        logic peer_stamp;
        logic peer_fail;
    } tbl_cmd_t;

endpackage

// ----- hw/rtl/dvrt_if.sv -----
interface dvrt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [1:0]  arrival_port;
    logic [3:0]  target_node;
    logic [7:0]  advertised_cost;
    logic [31:0] time_now;

    modport source (
        output valid, operation, arrival_port, target_node, advertised_cost, time_now,
        input  ready
    );
    modport sink (
        input  valid, operation, arrival_port, target_node, advertised_cost, time_now,
        output ready
    );
endinterface

interface dvrt_adv_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_port;
    logic [3:0] adv_node;
    logic [7:0] adv_cost;
    logic       last_of_run;

    modport source (
        output valid, out_port, adv_node, adv_cost, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, out_port, adv_node, adv_cost, last_of_run,
        output ready
    );
endinterface

// ----- hw/rtl/distance_vector_route_table.sv -----
// channel   dir  handshake     payload
// req       in   valid/ready   operation, arrival_port, target_node, advertised_cost, time_now
// adv       out  valid/ready   out_port, adv_node, adv_cost, last_of_run
// apb       in   psel/penable  paddr, pwdata, prdata, pready (always 1)
//
// Update: looks up the target node; when the route changes, walks the min(ports_in_use, 4) ports to advertise it.
// Periodic: walks every node and advertises each valid route and the self node on those ports.
// Check: ages each seen port; for each failed port, walks every node and drops and advertises
// each route through that port.
// A single sequencer walks the table entry by entry; it takes a new request only when idle.
// Reset clears control state and valid bits at once; no clearing pass.
// A one-word pending stage and the output register hold words; the walk stalls when both are full.
module distance_vector_route_table #(
    parameter int NODE_COUNT = 16,
    parameter int PORT_COUNT = 4,
    parameter int COST_BITS  = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    dvrt_req_if.sink                    req,
    dvrt_adv_if.source                  adv,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dvrt_pkg::ADDR_W-1:0] paddr,
    input  logic [dvrt_pkg::DATA_W-1:0] pwdata,
    output logic [dvrt_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int NW = $clog2(NODE_COUNT);
    localparam int PW = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;

    dvrt_pkg::cfg_t      cfg;
    dvrt_pkg::tbl_cmd_t  cmd;
    logic [NW-1:0]        route_addr;
    logic [PW-1:0]        route_wport;
    logic [COST_BITS-1:0] route_wcost;
    logic                 route_valid;
    logic [PW-1:0]        route_hop;
    logic [COST_BITS-1:0] route_cost;
    logic [PW-1:0]        peer_addr;
    logic [31:0]          peer_wtime;
    logic                 peer_valid;
    logic [31:0]          peer_time;

    dvrt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dvrt_table #(
        .NODE_COUNT (NODE_COUNT),
        .PORT_COUNT (PORT_COUNT),
        .COST_BITS  (COST_BITS)
    ) u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .route_addr  (route_addr),
        .route_wport (route_wport),
        .route_wcost (route_wcost),
        .route_valid (route_valid),
        .route_hop   (route_hop),
        .route_cost  (route_cost),
        .peer_addr   (peer_addr),
        .peer_wtime  (peer_wtime),
        .peer_valid  (peer_valid),
        .peer_time   (peer_time)
    );

    dvrt_ctrl #(
        .NODE_COUNT (NODE_COUNT),
        .PORT_COUNT (PORT_COUNT),
        .COST_BITS  (COST_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .req         (req),
        .adv         (adv),
        .cmd         (cmd),
        .route_addr  (route_addr),
        .route_wport (route_wport),
        .route_wcost (route_wcost),
        .route_valid (route_valid),
        .route_hop   (route_hop),
        .route_cost  (route_cost),
        .peer_addr   (peer_addr),
        .peer_wtime  (peer_wtime),
        .peer_valid  (peer_valid),
        .peer_time   (peer_time)
    );

endmodule

// ----- hw/rtl/dvrt_cfg.sv -----
module dvrt_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dvrt_pkg::ADDR_W-1:0] paddr,
    input  logic [dvrt_pkg::DATA_W-1:0] pwdata,
    output logic [dvrt_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output dvrt_pkg::cfg_t              cfg
);

    dvrt_pkg::cfg_t cfg_reg;
    dvrt_pkg::cfg_t cfg_next;
    logic [2:0]     reg_idx;
    logic           wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                dvrt_pkg::REG_INFINITY_COST: cfg_next.infinity_cost     = pwdata[7:0];
                dvrt_pkg::REG_SPLIT_HORIZON: cfg_next.split_horizon_on  = pwdata[0];
                dvrt_pkg::REG_POISON_REV:    cfg_next.poison_reverse_on = pwdata[0];
                dvrt_pkg::REG_SELF_NODE:     cfg_next.self_node_id      = pwdata[3:0];
                dvrt_pkg::REG_PORTS_IN_USE:  cfg_next.ports_in_use      = pwdata[2:0];
                dvrt_pkg::REG_PEER_TIMEOUT:  cfg_next.peer_timeout      = pwdata;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            dvrt_pkg::REG_INFINITY_COST: prdata = 32'(cfg_reg.infinity_cost);
            dvrt_pkg::REG_SPLIT_HORIZON: prdata = 32'(cfg_reg.split_horizon_on);
            dvrt_pkg::REG_POISON_REV:    prdata = 32'(cfg_reg.poison_reverse_on);
            dvrt_pkg::REG_SELF_NODE:     prdata = 32'(cfg_reg.self_node_id);
            dvrt_pkg::REG_PORTS_IN_USE:  prdata = 32'(cfg_reg.ports_in_use);
            dvrt_pkg::REG_PEER_TIMEOUT:  prdata = cfg_reg.peer_timeout;
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.infinity_cost     <= dvrt_pkg::RST_INFINITY_COST;
            cfg_reg.split_horizon_on  <= 1'b0;
            cfg_reg.poison_reverse_on <= 1'b0;
            cfg_reg.self_node_id      <= 4'd0;
            cfg_reg.ports_in_use      <= dvrt_pkg::RST_PORTS_IN_USE;
            cfg_reg.peer_timeout      <= dvrt_pkg::RST_PEER_TIMEOUT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- hw/rtl/dvrt_table.sv -----
module dvrt_table #(
    parameter int NODE_COUNT = 16,
    parameter int PORT_COUNT = 4,
    parameter int COST_BITS  = 8,
    localparam int NW = $clog2(NODE_COUNT),
    localparam int PW = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dvrt_pkg::tbl_cmd_t   cmd,
    input  logic [NW-1:0]        route_addr,
    input  logic [PW-1:0]        route_wport,
    input  logic [COST_BITS-1:0] route_wcost,
    output logic                 route_valid,
    output logic [PW-1:0]        route_hop,
    output logic [COST_BITS-1:0] route_cost,
    input  logic [PW-1:0]        peer_addr,
    input  logic [31:0]          peer_wtime,
    output logic                 peer_valid,
    output logic [31:0]          peer_time
);

    logic [NODE_COUNT-1:0] route_valid_reg;
    logic [PW-1:0]         route_hop_reg  [NODE_COUNT];
    logic [COST_BITS-1:0]  route_cost_reg [NODE_COUNT];
    logic [PORT_COUNT-1:0] peer_valid_reg;
    logic [31:0]           peer_time_reg  [PORT_COUNT];

    assign route_valid = route_valid_reg[route_addr];
    assign route_hop   = route_hop_reg[route_addr];
    assign route_cost  = route_cost_reg[route_addr];
    assign peer_valid  = peer_valid_reg[peer_addr];
    assign peer_time   = peer_time_reg[peer_addr];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            route_valid_reg <= '0;
            peer_valid_reg  <= '0;
        end
        else
        begin
            if (cmd.route_drop)
            begin
                route_valid_reg[route_addr] <= 1'b0;
            end
            else if (cmd.route_set)
            begin
                route_valid_reg[route_addr] <= 1'b1;
            end
            if (cmd.peer_fail)
            begin
                peer_valid_reg[peer_addr] <= 1'b0;
            end
            else if (cmd.peer_stamp)
            begin
                peer_valid_reg[peer_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.route_set)
        begin
            route_hop_reg[route_addr]  <= route_wport;
            route_cost_reg[route_addr] <= route_wcost;
        end
        if (cmd.peer_stamp)
        begin
            peer_time_reg[peer_addr] <= peer_wtime;
        end
    end

endmodule

// ----- hw/rtl/dvrt_ctrl.sv -----
module dvrt_ctrl #(
    parameter int NODE_COUNT = 16,
    parameter int PORT_COUNT = 4,
    parameter int COST_BITS  = 8,
    localparam int NW = $clog2(NODE_COUNT),
    localparam int PW = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dvrt_pkg::cfg_t       cfg,
    dvrt_req_if.sink             req,
    dvrt_adv_if.source           adv,
    output dvrt_pkg::tbl_cmd_t   cmd,
    output logic [NW-1:0]        route_addr,
    output logic [PW-1:0]        route_wport,
    output logic [COST_BITS-1:0] route_wcost,
    input  logic                 route_valid,
    input  logic [PW-1:0]        route_hop,
    input  logic [COST_BITS-1:0] route_cost,
    output logic [PW-1:0]        peer_addr,
    output logic [31:0]          peer_wtime,
    input  logic                 peer_valid,
    input  logic [31:0]          peer_time
);

    localparam int CMW      = (COST_BITS > 8) ? COST_BITS : 8;
    localparam int COST_MAX = (1 << COST_BITS) - 1;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_UPD   = 8'b0000_0010,
        S_NODE  = 8'b0000_0100,
        S_STEP  = 8'b0000_1000,
        S_AGE   = 8'b0001_0000,
        S_CMP   = 8'b0010_0000,
        S_PORT  = 8'b0100_0000,
        S_FLUSH = 8'b1000_0000
    } state_t;

    state_t                        state_reg, state_next;
    logic [1:0]                    op_reg, op_next;
    logic [1:0]                    port_reg, port_next;
    logic [3:0]                    node_reg, node_next;
    logic [7:0]                    advc_reg, advc_next;
    logic [31:0]                   now_reg, now_next;
    logic [NW-1:0]                 n_reg, n_next;
    logic [PW-1:0]                 cp_reg, cp_next;
    logic [31:0]                   age_reg, age_next;
    logic [dvrt_pkg::PCNT_W-1:0]   p_reg, p_next;
    logic [NW-1:0]                 ctx_node_reg, ctx_node_next;
    logic                          ctx_hop_vld_reg, ctx_hop_vld_next;
    logic [PW-1:0]                 ctx_hop_reg, ctx_hop_next;
    logic [7:0]                    ctx_cost_reg, ctx_cost_next;
    logic                          pend_valid_reg, pend_valid_next;
    logic [1:0]                    pend_port_reg, pend_port_next;
    logic [3:0]                    pend_node_reg, pend_node_next;
    logic [7:0]                    pend_cost_reg, pend_cost_next;
    logic                          out_valid_reg, out_valid_next;
    logic [1:0]                    out_port_reg, out_port_next;
    logic [3:0]                    out_node_reg, out_node_next;
    logic [7:0]                    out_cost_reg, out_cost_next;
    logic                          out_last_reg, out_last_next;

    logic                          accept;
    logic                          out_free;
    logic [dvrt_pkg::PCNT_W-1:0]   nports;
    logic [CMW:0]                  adv_ext;
    logic [CMW:0]                  cost_wide;
    logic [COST_BITS-1:0]          new_cost;
    logic [CMW-1:0]                new_cost_x;
    logic [CMW-1:0]                route_cost_x;
    logic [CMW-1:0]                inf_x;
    logic                          node_ok;
    logic                          port_ok;
    logic                          is_self;
    logic                          node_last;
    logic                          port_last;
    logic                          hop_match;
    logic                          emit;
    logic [7:0]                    emit_cost;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || adv.ready;

    assign adv.valid       = out_valid_reg;
    assign adv.out_port    = out_port_reg;
    assign adv.adv_node    = out_node_reg;
    assign adv.adv_cost    = out_cost_reg;
    assign adv.last_of_run = out_last_reg;

    assign nports = (cfg.ports_in_use > dvrt_pkg::PCNT_W'(PORT_COUNT))
                    ? dvrt_pkg::PCNT_W'(PORT_COUNT) : cfg.ports_in_use;

    assign adv_ext      = (CMW + 1)'(advc_reg);
    assign cost_wide    = (adv_ext >= (CMW + 1)'(COST_MAX)) ? (CMW + 1)'(COST_MAX)
                          : adv_ext + (CMW + 1)'(1);
    assign new_cost     = cost_wide[COST_BITS-1:0];
    assign new_cost_x   = CMW'(new_cost);
    assign route_cost_x = CMW'(route_cost);
    assign inf_x        = CMW'(cfg.infinity_cost);

    assign node_ok   = ({1'b0, node_reg} < 5'(NODE_COUNT))
                       && (node_reg != cfg.self_node_id);
    assign port_ok   = ({1'b0, port_reg} < 3'(PORT_COUNT));
    assign is_self   = (4'(n_reg) == cfg.self_node_id);
    assign node_last = (n_reg == NW'(NODE_COUNT - 1));
    assign port_last = (cp_reg == PW'(PORT_COUNT - 1));

    assign hop_match = ctx_hop_vld_reg && (dvrt_pkg::PCNT_W'(ctx_hop_reg) == p_reg);
    assign emit      = !(hop_match && cfg.split_horizon_on);
    assign emit_cost = (hop_match && cfg.poison_reverse_on) ? cfg.infinity_cost
                       : ctx_cost_reg;

    assign route_addr  = (state_reg == S_UPD) ? node_reg[NW-1:0] : n_reg;
    assign peer_addr   = (state_reg == S_UPD) ? port_reg[PW-1:0] : cp_reg;
    assign route_wport = port_reg[PW-1:0];
    assign route_wcost = new_cost;
    assign peer_wtime  = now_reg;

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        port_next        = port_reg;
        node_next        = node_reg;
        advc_next        = advc_reg;
        now_next         = now_reg;
        n_next           = n_reg;
        cp_next          = cp_reg;
        age_next         = age_reg;
        p_next           = p_reg;
        ctx_node_next    = ctx_node_reg;
        ctx_hop_vld_next = ctx_hop_vld_reg;
        ctx_hop_next     = ctx_hop_reg;
        ctx_cost_next    = ctx_cost_reg;
        pend_valid_next  = pend_valid_reg;
        pend_port_next   = pend_port_reg;
        pend_node_next   = pend_node_reg;
        pend_cost_next   = pend_cost_reg;
        out_valid_next   = adv.ready ? 1'b0 : out_valid_reg;
        out_port_next    = out_port_reg;
        out_node_next    = out_node_reg;
        out_cost_next    = out_cost_reg;
        out_last_next    = out_last_reg;
        cmd              = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next   = req.operation;
                    port_next = req.arrival_port;
                    node_next = req.target_node;
                    advc_next = req.advertised_cost;
                    now_next  = req.time_now;
                    n_next    = '0;
                    cp_next   = '0;
                    priority if (req.operation == dvrt_pkg::OP_UPDATE)
                    begin
                        state_next = S_UPD;
                    end
                    else if (req.operation == dvrt_pkg::OP_PERIODIC)
                    begin
                        state_next = S_NODE;
                    end
                    else if (req.operation == dvrt_pkg::OP_CHECK)
                    begin
                        state_next = S_AGE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_UPD:
            begin
                state_next       = S_FLUSH;
                p_next           = '0;
                ctx_node_next    = node_reg[NW-1:0];
                ctx_hop_vld_next = 1'b1;
                ctx_hop_next     = port_reg[PW-1:0];
                ctx_cost_next    = new_cost_x[7:0];
                if (port_ok)
                begin
                    cmd.peer_stamp = 1'b1;
                    if (node_ok)
                    begin
                        priority if (!route_valid)
                        begin
                            if (new_cost_x < inf_x)
                            begin
                                cmd.route_set = 1'b1;
                                state_next    = S_PORT;
                            end
                        end
                        else if (new_cost < route_cost)
                        begin
                            cmd.route_set = 1'b1;
                            state_next    = S_PORT;
                        end
                        else if (new_cost > route_cost && route_hop == port_reg[PW-1:0])
                        begin
                            cmd.route_set  = 1'b1;
                            cmd.route_drop = (new_cost_x >= inf_x);
                            state_next     = S_PORT;
                        end
                        else
                        begin
                            state_next = S_FLUSH;
                        end
                    end
                end
            end

            S_NODE:
            begin
                p_next        = '0;
                ctx_node_next = n_reg;
                state_next    = S_STEP;
                if (op_reg == dvrt_pkg::OP_PERIODIC)
                begin
                    priority if (is_self)
                    begin
                        ctx_hop_vld_next = 1'b0;
                        ctx_hop_next     = '0;
                        ctx_cost_next    = 8'd0;
                        state_next       = S_PORT;
                    end
                    else if (route_valid)
                    begin
                        ctx_hop_vld_next = 1'b1;
                        ctx_hop_next     = route_hop;
                        ctx_cost_next    = route_cost_x[7:0];
                        state_next       = S_PORT;
                    end
                    else
                    begin
                        state_next = S_STEP;
                    end
                end
                else if (!is_self && route_valid && route_hop == cp_reg)
                begin
                    cmd.route_drop   = 1'b1;
                    ctx_hop_vld_next = 1'b1;
                    ctx_hop_next     = cp_reg;
                    ctx_cost_next    = cfg.infinity_cost;
                    state_next       = S_PORT;
                end
            end

            S_STEP:
            begin
                if (!node_last)
                begin
                    n_next     = n_reg + NW'(1);
                    state_next = S_NODE;
                end
                else if (op_reg == dvrt_pkg::OP_PERIODIC || port_last)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    cp_next    = cp_reg + PW'(1);
                    state_next = S_AGE;
                end
            end

            S_AGE:
            begin
                if (peer_valid)
                begin
                    age_next   = now_reg - peer_time;
                    state_next = S_CMP;
                end
                else if (port_last)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    cp_next = cp_reg + PW'(1);
                end
            end

            S_CMP:
            begin
                if (age_reg > cfg.peer_timeout)
                begin
                    cmd.peer_fail = 1'b1;
                    n_next        = '0;
                    state_next    = S_NODE;
                end
                else if (port_last)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    cp_next    = cp_reg + PW'(1);
                    state_next = S_AGE;
                end
            end

            S_PORT:
            begin
                if (p_reg >= nports)
                begin
                    state_next = (op_reg == dvrt_pkg::OP_UPDATE) ? S_FLUSH : S_STEP;
                end
                else if (!emit)
                begin
                    p_next = p_reg + dvrt_pkg::PCNT_W'(1);
                end
                else if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_port_next  = pend_port_reg;
                        out_node_next  = pend_node_reg;
                        out_cost_next  = pend_cost_reg;
                        out_last_next  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_port_next  = p_reg[1:0];
                    pend_node_next  = 4'(ctx_node_reg);
                    pend_cost_next  = emit_cost;
                    p_next          = p_reg + dvrt_pkg::PCNT_W'(1);
                end
            end

            S_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_port_next   = pend_port_reg;
                    out_node_next   = pend_node_reg;
                    out_cost_next   = pend_cost_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        port_reg        <= port_next;
        node_reg        <= node_next;
        advc_reg        <= advc_next;
        now_reg         <= now_next;
        n_reg           <= n_next;
        cp_reg          <= cp_next;
        age_reg         <= age_next;
        p_reg           <= p_next;
        ctx_node_reg    <= ctx_node_next;
        ctx_hop_vld_reg <= ctx_hop_vld_next;
        ctx_hop_reg     <= ctx_hop_next;
        ctx_cost_reg    <= ctx_cost_next;
        pend_port_reg   <= pend_port_next;
        pend_node_reg   <= pend_node_next;
        pend_cost_reg   <= pend_cost_next;
        out_port_reg    <= out_port_next;
        out_node_reg    <= out_node_next;
        out_cost_reg    <= out_cost_next;
        out_last_reg    <= out_last_next;
    end

endmodule

// ----- dv/tb_distance_vector_route_table.sv -----
`timescale 1ns / 1ps

module tb_distance_vector_route_table;
    import dvrt_pkg::*;

    localparam int NODES         = 16;
    localparam int PORTS         = 4;
    localparam int SETTLE_CYCLES = 300;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 17;
    localparam int PHASES        = 6;

    typedef struct {
        logic [1:0] out_port;
        logic [3:0] adv_node;
        logic [7:0] adv_cost;
        logic       tail;
    } adv_word_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    dvrt_req_if req_bus ();
    dvrt_adv_if adv_bus ();

    distance_vector_route_table dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_bus),
        .adv     (adv_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    adv_word_t adv_pending[$];
    adv_word_t run_words[$];
    int        errors;
    int        cycles;
    int        stall_mode;
    int        stall_run;

    cfg_t        cfg;
    logic        route_ok     [NODES];
    logic [1:0]  route_hop    [NODES];
    logic [7:0]  route_metric [NODES];
    logic        peer_ok      [PORTS];
    logic [31:0] peer_stamp   [PORTS];
    logic [31:0] clock_now;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(negedge clk) begin
        case (stall_mode)
            0: adv_bus.ready = 1'b1;
            1: adv_bus.ready = ($urandom_range(0, 3) != 0);
            2: begin
                if (stall_run > 0) begin
                    adv_bus.ready = 1'b0;
                    stall_run--;
                end
                else begin
                    adv_bus.ready = 1'b1;
                    if ($urandom_range(0, 5) == 0)
                        stall_run = $urandom_range(1, 8);
                end
            end
            default: adv_bus.ready = ~adv_bus.ready;
        endcase
    end

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH at %0t: %s got %0h, want %0h", $time, what, got, want);
        errors++;
    endtask

    always @(posedge clk) begin : adv_check
        adv_word_t want;
        if (rst_n && adv_bus.valid === 1'b1 && adv_bus.ready === 1'b1) begin
            if (adv_pending.size() == 0)
                report_mismatch("unexpected word, node", adv_bus.adv_node, 0);
            else begin
                want = adv_pending.pop_front();
                if (adv_bus.out_port !== want.out_port)
                    report_mismatch("out_port", adv_bus.out_port, want.out_port);
                if (adv_bus.adv_node !== want.adv_node)
                    report_mismatch("adv_node", adv_bus.adv_node, want.adv_node);
                if (adv_bus.adv_cost !== want.adv_cost)
                    report_mismatch("adv_cost", adv_bus.adv_cost, want.adv_cost);
                if (adv_bus.last_of_run !== want.tail)
                    report_mismatch("last_of_run", adv_bus.last_of_run, want.tail);
            end
        end
    end

    function automatic void push_adv(int port, int node, int cost);
        adv_word_t w;
        w.out_port = 2'(port);
        w.adv_node = 4'(node);
        w.adv_cost = 8'(cost);
        w.tail     = 1'b0;
        run_words.push_back(w);
    endfunction

    function automatic void advertise_route(int node, bit has_hop, int hop, int cost);
        int nports;
        int c;
        nports = (cfg.ports_in_use > PORTS) ? PORTS : int'(cfg.ports_in_use);
        for (int p = 0; p < nports; p++) begin
            c = cost;
            if (has_hop && p == hop) begin
                if (cfg.split_horizon_on)
                    continue;
                if (cfg.poison_reverse_on)
                    c = cfg.infinity_cost;
            end
            push_adv(p, node, c);
        end
    endfunction

    function automatic void apply_update(int port, int node, int adv_in, logic [31:0] now);
        int metric;
        metric = (adv_in >= 255) ? 255 : adv_in + 1;
        if (node != cfg.self_node_id) begin
            if (!route_ok[node]) begin
                if (metric < cfg.infinity_cost) begin
                    route_ok[node]     = 1'b1;
                    route_hop[node]    = 2'(port);
                    route_metric[node] = 8'(metric);
                    advertise_route(node, 1'b1, port, metric);
                end
            end
            else if (metric < route_metric[node]) begin
                route_hop[node]    = 2'(port);
                route_metric[node] = 8'(metric);
                advertise_route(node, 1'b1, port, metric);
            end
            else if (metric > route_metric[node] && route_hop[node] == port) begin
                route_metric[node] = 8'(metric);
                advertise_route(node, 1'b1, port, metric);
                if (metric >= cfg.infinity_cost)
                    route_ok[node] = 1'b0;
            end
        end
        peer_ok[port]    = 1'b1;
        peer_stamp[port] = now;
    endfunction

    function automatic void run_periodic();
        for (int n = 0; n < NODES; n++) begin
            if (n == cfg.self_node_id)
                advertise_route(n, 1'b0, 0, 0);
            else if (route_ok[n])
                advertise_route(n, 1'b1, route_hop[n], route_metric[n]);
        end
    endfunction

    function automatic void run_liveness(logic [31:0] now);
        logic [31:0] age;
        for (int p = 0; p < PORTS; p++) begin
            if (!peer_ok[p])
                continue;
            age = now - peer_stamp[p];
            if (age > cfg.peer_timeout) begin
                for (int n = 0; n < NODES; n++) begin
                    if (n == cfg.self_node_id || !route_ok[n])
                        continue;
                    if (route_hop[n] == p) begin
                        route_metric[n] = cfg.infinity_cost;
                        advertise_route(n, 1'b1, p, cfg.infinity_cost);
                        route_ok[n] = 1'b0;
                    end
                end
                peer_ok[p] = 1'b0;
            end
        end
    endfunction

    function automatic void predict_item(logic [1:0] op, logic [1:0] port, logic [3:0] node,
                                         logic [7:0] cost, logic [31:0] now);
        adv_word_t w;
        run_words.delete();
        case (op)
            OP_UPDATE:   apply_update(port, node, cost, now);
            OP_PERIODIC: run_periodic();
            OP_CHECK:    run_liveness(now);
            default:     ;
        endcase
        foreach (run_words[i]) begin
            w      = run_words[i];
            w.tail = (i == run_words.size() - 1);
            adv_pending.push_back(w);
        end
    endfunction

    task automatic send_item(logic [1:0] op, logic [1:0] port, logic [3:0] node,
                             logic [7:0] cost, logic [31:0] now);
        @(negedge clk);
        req_bus.valid           = 1'b1;
        req_bus.operation       = op;
        req_bus.arrival_port    = port;
        req_bus.target_node     = node;
        req_bus.advertised_cost = cost;
        req_bus.time_now        = now;
        do @(posedge clk); while (req_bus.ready !== 1'b1);
        predict_item(op, port, node, cost, now);
    endtask

    task automatic hold_off(int n);
        @(negedge clk);
        req_bus.valid = 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic drain_results();
        @(negedge clk);
        req_bus.valid = 1'b0;
        while (adv_pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_reg(logic [2:0] idx, logic [31:0] want);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (prdata !== want)
            report_mismatch($sformatf("register %0d read", idx), prdata, want);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic check_all_regs();
        check_reg(REG_INFINITY_COST, 32'(cfg.infinity_cost));
        check_reg(REG_SPLIT_HORIZON, 32'(cfg.split_horizon_on));
        check_reg(REG_POISON_REV, 32'(cfg.poison_reverse_on));
        check_reg(REG_SELF_NODE, 32'(cfg.self_node_id));
        check_reg(REG_PORTS_IN_USE, 32'(cfg.ports_in_use));
        check_reg(REG_PEER_TIMEOUT, cfg.peer_timeout);
    endtask

    task automatic configure(logic [7:0] inf, logic split, logic poison, logic [3:0] self_id,
                             logic [2:0] ports, logic [31:0] timeout);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(REG_INFINITY_COST, 32'(inf));
        write_reg(REG_SPLIT_HORIZON, 32'(split));
        write_reg(REG_POISON_REV, 32'(poison));
        write_reg(REG_SELF_NODE, 32'(self_id));
        write_reg(REG_PORTS_IN_USE, 32'(ports));
        write_reg(REG_PEER_TIMEOUT, timeout);
        cfg.infinity_cost     = inf;
        cfg.split_horizon_on  = split;
        cfg.poison_reverse_on = poison;
        cfg.self_node_id      = self_id;
        cfg.ports_in_use      = ports;
        cfg.peer_timeout      = timeout;
        check_all_regs();
    endtask

    task automatic test_register_defaults();
        check_all_regs();
    endtask

    task automatic test_update_rules();
        send_item(OP_UPDATE, 2'd1, 4'd5, 8'd3, 32'd100);
        send_item(OP_UPDATE, 2'd2, 4'd5, 8'd3, 32'd101);
        send_item(OP_UPDATE, 2'd2, 4'd5, 8'd1, 32'd102);
        send_item(OP_UPDATE, 2'd1, 4'd5, 8'd0, 32'd103);
        send_item(OP_UPDATE, 2'd1, 4'd5, 8'd7, 32'd104);
        send_item(OP_UPDATE, 2'd3, 4'd5, 8'd9, 32'd105);
        send_item(OP_UPDATE, 2'd1, 4'd5, 8'd15, 32'd106);
        send_item(OP_UPDATE, 2'd0, 4'd0, 8'd2, 32'd107);
        send_item(OP_UPDATE, 2'd0, 4'd15, 8'd255, 32'd108);
        send_item(OP_UPDATE, 2'd3, 4'd15, 8'd0, 32'hFFFF_FFF0);
        send_item(OP_UPDATE, 2'd2, 4'd9, 8'd14, 32'd110);
    endtask

    task automatic test_advertise_and_check();
        send_item(OP_PERIODIC, 2'd0, 4'd0, 8'd0, 32'd0);
        send_item(OP_UNUSED, 2'd3, 4'd15, 8'd255, 32'hFFFF_FFFF);
        // port 3 stamped just before the wrap stays alive, older ports fail
        send_item(OP_CHECK, 2'd0, 4'd0, 8'd0, 32'h0000_0010);
        send_item(OP_PERIODIC, 2'd0, 4'd0, 8'd0, 32'd0);
        send_item(OP_CHECK, 2'd0, 4'd0, 8'd0, 32'h0000_03F0);
        send_item(OP_PERIODIC, 2'd0, 4'd0, 8'd0, 32'd0);
    endtask

    task automatic test_horizon_and_ports();
        configure(8'd16, 1'b1, 1'b0, 4'd0, 3'd4, 32'd1000);
        send_item(OP_UPDATE, 2'd1, 4'd3, 8'd2, 32'd500);
        send_item(OP_UPDATE, 2'd3, 4'd7, 8'd4, 32'd501);
        send_item(OP_PERIODIC, 2'd0, 4'd0, 8'd0, 32'd502);
        configure(8'd16, 1'b0, 1'b1, 4'd0, 3'd4, 32'd1000);
        send_item(OP_PERIODIC, 2'd0, 4'd0, 8'd0, 32'd503);
        // route via port 3 is outside the two ports in use
        configure(8'd16, 1'b1, 1'b1, 4'd0, 3'd2, 32'd1000);
        send_item(OP_PERIODIC, 2'd0, 4'd0, 8'd0, 32'd504);
        configure(8'd16, 1'b0, 1'b1, 4'd0, 3'd0, 32'd1000);
        send_item(OP_UPDATE, 2'd0, 4'd12, 8'd1, 32'd505);
        send_item(OP_PERIODIC, 2'd0, 4'd0, 8'd0, 32'd506);
        configure(8'd16, 1'b0, 1'b1, 4'd15, 3'd7, 32'd1000);
        send_item(OP_PERIODIC, 2'd0, 4'd0, 8'd0, 32'd507);
    endtask

    task automatic test_random_traffic();
        int          counted;
        int          burst_left;
        int          pick;
        logic [1:0]  op;
        logic [1:0]  port;
        logic [3:0]  node;
        logic [7:0]  cost;
        logic [31:0] step;
        int          near;
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: configure(8'd254, 1'b1, 1'b0, 4'd15, 3'd1, 32'd1);
                1: configure(8'd1, 1'b0, 1'b1, 4'd0, 3'd4, 32'hFFFF_FFFF);
                default: begin
                    pick = $urandom_range(0, 2);
                    configure(($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 254))
                                                          : 8'($urandom_range(4, 40)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                              (pick == 0) ? 32'($urandom_range(1, 64)) :
                              (pick == 1) ? 32'($urandom_range(100, 5000)) : $urandom);
                end
            endcase
            stall_mode = phase % 4;
            clock_now  = $urandom;
            counted    = 0;
            burst_left = $urandom_range(1, 10);
            while (counted < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                op   = (pick < 60) ? OP_UPDATE : (pick < 78) ? OP_PERIODIC :
                       (pick < 95) ? OP_CHECK : OP_UNUSED;
                port = 2'($urandom_range(0, 3));
                node = 4'($urandom_range(0, 15));
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    cost = 8'($urandom_range(0, cfg.infinity_cost));
                else if (pick < 90 && route_ok[node]) begin
                    near = int'(route_metric[node]) - 2 + $urandom_range(0, 2);
                    cost = (near < 0) ? 8'd0 : 8'(near);
                end
                else
                    cost = 8'($urandom_range(0, 255));
                if (cfg.peer_timeout < 64)
                    step = $urandom_range(0, 2 * cfg.peer_timeout);
                else if ($urandom_range(0, 3) == 0)
                    step = cfg.peer_timeout + $urandom_range(1, 100);
                else
                    step = $urandom_range(0, cfg.peer_timeout / 4);
                clock_now += step;
                send_item(op, port, node, cost, clock_now);
                if (op != OP_UNUSED)
                    counted++;
                if (phase == 2) begin
                    if (counted % 4 == 0)
                        drain_results();
                end
                else if (phase != 3) begin
                    burst_left--;
                    if (burst_left == 0) begin
                        hold_off($urandom_range(1, 6));
                        burst_left = $urandom_range(1, 10);
                    end
                end
            end
        end
    endtask

    initial begin
        rst_n                   = 1'b0;
        psel                    = 1'b0;
        penable                 = 1'b0;
        pwrite                  = 1'b0;
        paddr                   = '0;
        pwdata                  = '0;
        req_bus.valid           = 1'b0;
        req_bus.operation       = OP_UPDATE;
        req_bus.arrival_port    = 2'd0;
        req_bus.target_node     = 4'd0;
        req_bus.advertised_cost = 8'd0;
        req_bus.time_now        = 32'd0;
        adv_bus.ready           = 1'b0;
        errors                  = 0;
        cycles                  = 0;
        stall_mode              = 1;
        stall_run               = 0;
        clock_now               = 32'd0;

        cfg.infinity_cost     = RST_INFINITY_COST;
        cfg.split_horizon_on  = 1'b0;
        cfg.poison_reverse_on = 1'b0;
        cfg.self_node_id      = 4'd0;
        cfg.ports_in_use      = RST_PORTS_IN_USE;
        cfg.peer_timeout      = RST_PEER_TIMEOUT;
        for (int n = 0; n < NODES; n++) begin
            route_ok[n]     = 1'b0;
            route_hop[n]    = 2'd0;
            route_metric[n] = 8'd0;
        end
        for (int p = 0; p < PORTS; p++) begin
            peer_ok[p]    = 1'b0;
            peer_stamp[p] = 32'd0;
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_register_defaults();
        test_update_rules();
        test_advertise_and_check();
        test_horizon_and_ports();
        test_random_traffic();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
